/* rtl/core/upd_pkg.sv */
package upd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  // up to three results from one input beat, emitted b0 first
  typedef struct packed {
    logic [1:0] cnt;
    logic       term;   // last result of the beat closes the string
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } upd_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // only meaningful when is_hex(c)
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else begin
      v = (c & 8'hDF) - 8'h37;   // fold to upper case, then 'A' - 10
    end
    hex_val = v[3:0];
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    plain_byte = (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

/* rtl/core/upd_front.sv */
module upd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             eos,
  output logic             push,
  output upd_pkg::upd_cmd_t cmd
);

  upd_pkg::upd_phase_t phase_r, phase_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                c_hex, c_pct;
  logic [7:0]          fb;

  assign c_hex = upd_pkg::is_hex(in_byte);
  assign c_pct = (in_byte == upd_pkg::CH_PCT);
  assign fb    = upd_pkg::plain_byte(in_byte);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (accept) begin
      if (eos) begin
        phase_nxt = upd_pkg::PH_IDLE;
      end else begin
        case (phase_r)
          upd_pkg::PH_PCT: begin
            if (c_hex) begin
              phase_nxt = upd_pkg::PH_DIGIT;
              held_nxt  = in_byte;
            end else begin
              phase_nxt = c_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
            end
          end
          upd_pkg::PH_DIGIT: begin
            if (c_hex) begin
              phase_nxt = upd_pkg::PH_IDLE;
            end else begin
              phase_nxt = c_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_nxt = c_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    cmd      = '0;
    if (eos) begin
      cmd.term = 1'b1;
      case (phase_r)
        upd_pkg::PH_PCT: begin
          cmd.cnt = 2'd2;
          cmd.b0  = upd_pkg::CH_PCT;
          cmd.b1  = upd_pkg::CH_NUL;
        end
        upd_pkg::PH_DIGIT: begin
          cmd.cnt = 2'd3;
          cmd.b0  = upd_pkg::CH_PCT;
          cmd.b1  = held_r;
          cmd.b2  = upd_pkg::CH_NUL;
        end
        default: begin
          cmd.cnt = 2'd1;
          cmd.b0  = upd_pkg::CH_NUL;
        end
      endcase
    end else begin
      case (phase_r)
        upd_pkg::PH_PCT: begin
          if (!c_hex) begin
            cmd.b0  = upd_pkg::CH_PCT;
            cmd.b1  = fb;
            cmd.cnt = c_pct ? 2'd1 : 2'd2;
          end
        end
        upd_pkg::PH_DIGIT: begin
          if (c_hex) begin
            cmd.cnt = 2'd1;
            cmd.b0  = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(in_byte)};
          end else begin
            // broken escape: replay '%' and the held digit, then the new byte unless it is '%'
            cmd.b0  = upd_pkg::CH_PCT;
            cmd.b1  = held_r;
            cmd.b2  = fb;
            cmd.cnt = c_pct ? 2'd2 : 2'd3;
          end
        end
        default: begin
          cmd.b0  = fb;
          cmd.cnt = c_pct ? 2'd0 : 2'd1;
        end
      endcase
    end
  end

  assign push = accept && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_IDLE;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* rtl/core/upd_queue.sv */
module upd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              head_vld,
  output upd_pkg::upd_cmd_t head_cmd
);

  upd_pkg::upd_cmd_t       mem_r [upd_pkg::QDEPTH];
  logic [upd_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [upd_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (upd_pkg::QAW+1)'(upd_pkg::QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/upd_back.sv */
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_vld,
  input  upd_pkg::upd_cmd_t head_cmd,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  upd_pkg::upd_cmd_t work_r;
  logic              work_vld_r;
  logic [1:0]        idx_r;
  logic              last, take, load;

  assign last = (idx_r == work_r.cnt - 2'd1);
  assign take = work_vld_r && out_tready;
  assign load = !work_vld_r || (take && last);
  assign pop  = load && head_vld;

  always_comb begin
    case (idx_r)
      2'd0:    out_tdata = work_r.b0;
      2'd1:    out_tdata = work_r.b1;
      default: out_tdata = work_r.b2;
    endcase
  end

  assign out_tvalid = work_vld_r;
  assign out_tlast  = last;
  assign out_tuser  = work_r.term && last;

  always_ff @(posedge clk) begin
    if (load) begin
      work_r <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= 1'b0;
      idx_r      <= '0;
    end else if (load) begin
      work_vld_r <= head_vld;
      idx_r      <= '0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

/* rtl/core/url_percent_decoder_top.sv */
// channel | dir | tdata           | tuser             | tlast
// in_     | in  | [7:0] in_byte   | [0] end_of_string | -
// out_    | out | [7:0] out_byte  | [0] is_terminator | last_in_run
//
// One input beat per cycle when each beat yields at most one result and
// out_tready is high. A broken escape or an end of string yields up to
// three results and backs up the 4-entry command queue, which is what
// drops in_tready. Results pass the queue, then the output register.
// rst_n is synchronous and clears escape state, queue and output stage.
module url_percent_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] end_of_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] is_terminator
  output logic       out_tlast
);

  upd_pkg::upd_cmd_t push_cmd, head_cmd;
  logic              push, pop, full, head_vld, accept;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .eos     (in_tuser),
    .push    (push),
    .cmd     (push_cmd)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .head_vld (head_vld),
    .head_cmd (head_cmd)
  );

  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/core/upd_checker.sv */
module upd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // terminator is always the final result of its beat and carries zero
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("terminator not last or nonzero");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input blocked right after reset");

  // results of one beat leave back to back
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a result run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (.*);

/* tb/url_percent_decoder_top_test.sv */
typedef struct packed {
  logic [7:0] value;
  logic       term;
  logic       last;
} dec_result_t;

class decode_scoreboard;
  upd_pkg::upd_phase_t phase;
  logic [7:0]    held_char;
  dec_result_t   pending_q[$];
  int unsigned   errors;
  int unsigned   n_inputs;
  int unsigned   n_results;
  int unsigned   n_strings;
  int unsigned   n_decoded;
  int unsigned   n_broken;

  function new();
    phase     = upd_pkg::PH_IDLE;
    held_char = upd_pkg::CH_NUL;
  endfunction

  function bit decode_hex(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] u;
    u = c;
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") u = c - ("a" - "A");
    if (u >= "A" && u <= "F") begin
      v = 4'(u - ("A" - 8'd10));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void push(input logic [7:0] b, input logic term);
    dec_result_t r;
    r.value = b;
    r.term  = term;
    r.last  = 1'b0;
    pending_q.push_back(r);
  endfunction

  // byte seen with no escape open
  function void plain(input logic [7:0] c);
    if (c == upd_pkg::CH_PCT) phase = upd_pkg::PH_PCT;
    else if (c == upd_pkg::CH_PLUS) push(upd_pkg::CH_SPACE, 1'b0);
    else push(c, 1'b0);
  endfunction

  function void note_input(input logic [7:0] c, input logic eos);
    int unsigned start;
    logic [3:0]  hi;
    logic [3:0]  lo;
    start = pending_q.size();
    n_inputs++;
    if (eos) begin
      if (phase == upd_pkg::PH_PCT || phase == upd_pkg::PH_DIGIT) push(upd_pkg::CH_PCT, 1'b0);
      if (phase == upd_pkg::PH_DIGIT) push(held_char, 1'b0);
      push(upd_pkg::CH_NUL, 1'b1);
      phase = upd_pkg::PH_IDLE;
      n_strings++;
    end else begin
      case (phase)
        upd_pkg::PH_PCT: begin
          if (decode_hex(c, hi)) begin
            held_char = c;
            phase     = upd_pkg::PH_DIGIT;
          end else begin
            phase = upd_pkg::PH_IDLE;
            n_broken++;
            push(upd_pkg::CH_PCT, 1'b0);
            plain(c);
          end
        end
        upd_pkg::PH_DIGIT: begin
          phase = upd_pkg::PH_IDLE;
          if (decode_hex(c, lo)) begin
            void'(decode_hex(held_char, hi));
            push({hi, lo}, 1'b0);
            n_decoded++;
          end else begin
            n_broken++;
            push(upd_pkg::CH_PCT, 1'b0);
            push(held_char, 1'b0);
            plain(c);
          end
        end
        default: plain(c);
      endcase
    end
    if (pending_q.size() > start) pending_q[pending_q.size() - 1].last = 1'b1;
  endfunction

  function void check_result(input logic [7:0] b, input logic term, input logic last);
    dec_result_t want;
    if (pending_q.size() == 0) begin
      $error("result beat with nothing pending: out_byte %h is_terminator %b last_in_run %b",
             b, term, last);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    n_results++;
    if (b !== want.value) begin
      $error("out_byte: expected %h, actual %h", want.value, b);
      errors++;
    end
    if (term !== want.term) begin
      $error("is_terminator: expected %b, actual %b", want.term, term);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_in_run: expected %b, actual %b", want.last, last);
      errors++;
    end
  endfunction
endclass

module url_percent_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;
  bit rx_hold_req = 1'b0;

  decode_scoreboard board = new();

  url_percent_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: random backpressure or steady readiness, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 8'd10) return "0" + v;
    if ($urandom_range(1) != 0) return "a" + v - 8'd10;
    return "A" + v - 8'd10;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(b, eos);
    if (!tx_steady && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_token();
    int unsigned pick;
    logic [3:0]  dummy;
    logic [7:0]  junk;
    pick = $urandom_range(99);
    junk = 8'($urandom_range(255));
    if (pick < 35) begin
      send_item(upd_pkg::CH_PCT, 1'b0);
      send_item(hex_char(), 1'b0);
      send_item(hex_char(), 1'b0);
    end else if (pick < 50) begin
      send_item(upd_pkg::CH_PLUS, 1'b0);
    end else if (pick < 75) begin
      send_item(junk, 1'b0);
    end else if (pick < 87) begin
      // broken escape, with or without the first digit
      while (board.decode_hex(junk, dummy)) junk = 8'($urandom_range(255));
      send_item(upd_pkg::CH_PCT, 1'b0);
      if ($urandom_range(1) != 0) send_item(hex_char(), 1'b0);
      send_item(junk, 1'b0);
    end else if (pick < 95) begin
      send_item(junk, 1'b1);
    end else begin
      send_item(upd_pkg::CH_PCT, 1'b0);
      if ($urandom_range(1) != 0) send_item(hex_char(), 1'b0);
      send_item(junk, 1'b1);
    end
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_end();
    send_text("%4F%a0%00+");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("%g%9%+");
    send_text("%");
    send_end();
    send_text("%f");
    send_end();
    wait_drained();

    while (board.n_inputs < 110) begin
      if (!hold_done && board.n_inputs >= 40) begin
        // stall the output long enough for the input side to back up
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        repeat (12) send_item(8'($urandom_range(255)), 1'b0);
        tx_steady   = 1'b0;
      end
      if (!drain_done && board.n_inputs >= 60) begin
        drain_done = 1'b1;
        wait_drained();
      end
      tx_steady = (board.n_inputs >= 75 && board.n_inputs < 100);
      rx_steady = tx_steady;
      send_token();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d input beats and %0d result beats: %0d strings closed,",
             board.n_inputs, board.n_results, board.n_strings);
    $display("%0d escapes decoded, %0d escapes broken off", board.n_decoded, board.n_broken);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_queue.sv
rtl/core/upd_back.sv
rtl/core/url_percent_decoder_top.sv
rtl/core/upd_checker.sv
tb/url_percent_decoder_top_test.sv
